// File: rtl/substring_position_search_defines.svh
// Assertion macros for the substring position search RTL.
`ifndef SUBSTRING_POSITION_SEARCH_DEFINES_SVH
`define SUBSTRING_POSITION_SEARCH_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while reset is released.
`define SPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define SPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPS_ASSERT(label, clk, rst_n, prop, msg)
`define SPS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/sps_pkg.sv
// Types and constants of the substring position search.
`timescale 1ns / 1ps
package sps_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 65535;

  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W  = $clog2(TEXT_MAX + 1);
  localparam int POS_W  = 16;
  localparam int CALC_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
    logic last;
  } sps_cell_ctl_t;

endpackage

// File: rtl/sps_cell.sv
// One cell of the match chain: a pattern byte and its partial match bit.
`timescale 1ns / 1ps
module sps_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sps_pkg::sps_cell_ctl_t ctl,
  input  logic [7:0]            data_byte,
  input  logic                  match_in,
  output logic                  match_out,
  output logic                  hit
);
  import sps_pkg::*;

  logic [7:0] pat_r;
  logic       match_r;
  logic       match_nxt;

  // The text seen so far ends in the pattern prefix up to this cell.
  assign match_nxt = match_in & (data_byte == pat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.clear) begin
      match_r <= 1'b0;
    end else if (ctl.shift) begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pat_r <= data_byte;
    end
  end

  assign match_out = match_r;
  assign hit       = ctl.shift & ctl.last & match_nxt;

endmodule

// File: rtl/substring_position_search.sv
// Top level of the substring position search: control, counters and the cell chain.
// A result is registered in the output register, or in the second while it is stalled.
// Throughput: one word per cycle when not stalled; every cell takes a text word at once.
// The input stalls only while two results wait: one on a stalled output, one behind it.
// Reset (synchronous, active low) clears counters, flags and the chain match bits;
// pattern bytes in the cells are not reset, and only the last pattern cell drives a hit.
`timescale 1ns / 1ps
`include "substring_position_search_defines.svh"
module substring_position_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_position,
  output logic        out_overflow
);
  import sps_pkg::*;

  logic             in_acc;
  logic [LEN_W-1:0] pattern_len_r, pattern_len_nxt;
  logic [CNT_W-1:0] text_count_r, text_count_nxt;
  logic [POS_W-1:0] match_pos_r, match_pos_nxt;
  logic             match_found_r, match_found_nxt;
  logic             overflow_r, overflow_nxt;
  logic             pattern_over_r, pattern_over_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_position_r;
  logic             out_overflow_r;
  logic             skid_valid_r, skid_valid_nxt;
  logic [POS_W-1:0] skid_position_r;
  logic             skid_overflow_r;
  logic             out_free;
  logic             out_load_new, out_load_skid, skid_load;
  logic             do_clear, do_load, do_shift, do_end;
  logic [POS_W-1:0] report_pos;
  logic [CALC_W-1:0] new_pos;
  logic [PATTERN_MAX-1:0] hit_vec;
  logic [PATTERN_MAX:0]   chain;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    do_clear         = 1'b0;
    do_load          = 1'b0;
    do_shift         = 1'b0;
    do_end           = 1'b0;
    pattern_len_nxt  = pattern_len_r;
    text_count_nxt   = text_count_r;
    overflow_nxt     = overflow_r;
    pattern_over_nxt = pattern_over_r;
    if (in_acc) begin
      case (kind_t'(in_kind))
        KIND_START: begin
          do_clear         = 1'b1;
          pattern_len_nxt  = '0;
          text_count_nxt   = '0;
          overflow_nxt     = 1'b0;
          pattern_over_nxt = 1'b0;
        end
        KIND_PATTERN: begin
          if (text_count_r == '0) begin
            if (pattern_len_r == LEN_W'(PATTERN_MAX)) begin
              overflow_nxt     = 1'b1;
              pattern_over_nxt = 1'b1;
            end else begin
              do_load         = 1'b1;
              pattern_len_nxt = pattern_len_r + LEN_W'(1);
            end
          end
        end
        KIND_TEXT: begin
          if (text_count_r == CNT_W'(TEXT_MAX)) begin
            overflow_nxt = 1'b1;
          end else begin
            do_shift       = 1'b1;
            text_count_nxt = text_count_r + CNT_W'(1);
          end
        end
        KIND_END: begin
          do_end = 1'b1;
        end
        default: begin
          do_end = 1'b0;
        end
      endcase
    end
  end

  // Cell i takes the next pattern byte and is the last cell when the pattern is i+1 long.
  assign chain[0] = 1'b1;
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    sps_cell_ctl_t ctl;
    assign ctl.clear = do_clear;
    assign ctl.load  = do_load & (pattern_len_r == LEN_W'(i));
    assign ctl.shift = do_shift;
    assign ctl.last  = (pattern_len_r == LEN_W'(i + 1));
    sps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .data_byte (in_data_byte),
      .match_in  (chain[i]),
      .match_out (chain[i+1]),
      .hit       (hit_vec[i])
    );
  end

  assign new_pos = CALC_W'(text_count_nxt) + CALC_W'(1) - CALC_W'(pattern_len_r);

  always_comb begin
    match_found_nxt = match_found_r;
    match_pos_nxt   = match_pos_r;
    if (do_clear) begin
      match_found_nxt = 1'b0;
      match_pos_nxt   = '0;
    end else if (!match_found_r && !pattern_over_r && (|hit_vec)) begin
      match_found_nxt = 1'b1;
      match_pos_nxt   = new_pos[POS_W-1:0];
    end
  end

  always_comb begin
    if (pattern_over_r) begin
      report_pos = '0;
    end else if (pattern_len_r == '0) begin
      report_pos = POS_W'(1);
    end else if (match_found_r) begin
      report_pos = match_pos_r;
    end else begin
      report_pos = '0;
    end
  end

  // The second result register only fills while the output register waits on a stall.
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    out_load_new   = do_end & out_free;
    skid_load      = do_end & ~out_free;
    out_load_skid  = skid_valid_r & out_free;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_load_new || out_load_skid) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_load) begin
      skid_valid_nxt = 1'b1;
    end else if (out_load_skid) begin
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r  <= '0;
      text_count_r   <= '0;
      match_pos_r    <= '0;
      match_found_r  <= 1'b0;
      overflow_r     <= 1'b0;
      pattern_over_r <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      pattern_len_r  <= pattern_len_nxt;
      text_count_r   <= text_count_nxt;
      match_pos_r    <= match_pos_nxt;
      match_found_r  <= match_found_nxt;
      overflow_r     <= overflow_nxt;
      pattern_over_r <= pattern_over_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_skid) begin
      out_position_r <= skid_position_r;
      out_overflow_r <= skid_overflow_r;
    end else if (out_load_new) begin
      out_position_r <= report_pos;
      out_overflow_r <= overflow_r;
    end
    if (skid_load) begin
      skid_position_r <= report_pos;
      skid_overflow_r <= overflow_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_overflow = out_overflow_r;

  `SPS_ASSERT_ALWAYS(a_match_needs_pattern, clk,
    match_found_r |-> (!pattern_over_r && pattern_len_r != '0), "match latched without a valid pattern")
  `SPS_ASSERT_ALWAYS(a_match_within_text, clk,
    match_found_r |-> (CALC_W'(text_count_r) >= CALC_W'(pattern_len_r)), "match latched before enough text")
  `SPS_ASSERT(a_match_after_text, clk, rst_n,
    $rose(match_found_r) |-> $past(do_shift), "match latched without a text word")
  `SPS_ASSERT(a_pattern_locked, clk, rst_n,
    (text_count_r != '0) |-> $stable(pattern_len_r), "pattern changed after text started")
  `SPS_ASSERT(a_skid_behind_out, clk, rst_n,
    skid_valid_r |-> out_valid_r, "second result held without a first")

endmodule

// File: bench/substring_position_search_tb.sv
// Self-checking testbench of the substring position search: directed script, then random searches.
`timescale 1ns / 1ps
module substring_position_search_tb;
  import sps_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             overflow;
  } answer_t;

  // One row of the directed script; a typed answer overrides the predicted one.
  typedef struct {
    kind_t            kind;
    logic [7:0]       data;
    int               reps;
    bit               typed;
    logic [POS_W-1:0] pos;
    logic             ovf;
  } script_row_t;

  localparam int SCRIPT_ROWS = 27;
  script_row_t script [SCRIPT_ROWS] = '{
    '{KIND_END,     8'h00, 1,      1'b1, 16'd1,     1'b0},  // right after reset
    '{KIND_TEXT,    8'hFF, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_END,     8'h00, 1,      1'b1, 16'd1,     1'b0},  // empty pattern, some text
    '{KIND_START,   8'hAA, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_PATTERN, 8'hFF, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_PATTERN, 8'h00, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'h00, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_END,     8'h00, 1,      1'b1, 16'd0,     1'b0},  // pattern longer than text
    '{KIND_TEXT,    8'hFF, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'h00, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_END,     8'h00, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_PATTERN, 8'h55, 1,      1'b0, 16'd0,     1'b0},  // late pattern word
    '{KIND_END,     8'hFF, 1,      1'b0, 16'd0,     1'b0},  // repeated end
    '{KIND_START,   8'h00, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_PATTERN, 8'h3C, 65,     1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'h3C, 70,     1'b0, 16'd0,     1'b0},
    '{KIND_END,     8'h00, 1,      1'b1, 16'd0,     1'b1},  // pattern overflow
    '{KIND_START,   8'hFF, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_PATTERN, 8'hC3, 64,     1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'hC3, 64,     1'b0, 16'd0,     1'b0},
    '{KIND_END,     8'h00, 1,      1'b1, 16'd1,     1'b0},  // full-length pattern
    '{KIND_START,   8'h00, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_PATTERN, 8'hAB, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'h00, 65534,  1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'hAB, 1,      1'b0, 16'd0,     1'b0},
    '{KIND_TEXT,    8'h77, 2,      1'b0, 16'd0,     1'b0},
    '{KIND_END,     8'h00, 1,      1'b1, 16'd65535, 1'b1}   // widest position, text overflow
  };

  int SEND_IDLE  [4] = '{0, 49, 0, 6};
  int RECV_STALL [4] = '{0, 0, 49, 6};

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [1:0]       in_kind      = KIND_START;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [POS_W-1:0] out_position;
  logic             out_overflow;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  answer_t awaited_answers [$];

  // Predicted search state.
  logic [7:0]  pat_mem [PATTERN_MAX];
  logic [7:0]  win     [PATTERN_MAX];
  int unsigned pat_len;
  int unsigned txt_cnt;
  int unsigned hit_pos;
  bit          hit_seen;
  bit          ovf_seen;
  bit          pat_ovf;

  substring_position_search u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_overflow (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_search();
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_mem[i] = 8'h00;
      win[i]     = 8'h00;
    end
    pat_len  = 0;
    txt_cnt  = 0;
    hit_pos  = 0;
    hit_seen = 1'b0;
    ovf_seen = 1'b0;
    pat_ovf  = 1'b0;
  endfunction

  // Advances the predicted search by one word; returns 1 when the word yields an answer.
  function automatic bit search_step(input kind_t k, input logic [7:0] b, output answer_t a);
    bit hit;
    a = '0;
    case (k)
      KIND_START: begin
        clear_search();
      end
      KIND_PATTERN: begin
        // The pattern is locked once the first text word has been taken.
        if (txt_cnt == 0) begin
          if (pat_len >= PATTERN_MAX) begin
            ovf_seen = 1'b1;
            pat_ovf  = 1'b1;
          end else begin
            pat_mem[pat_len] = b;
            pat_len++;
          end
        end
      end
      KIND_TEXT: begin
        if (txt_cnt >= TEXT_MAX) begin
          ovf_seen = 1'b1;
        end else begin
          for (int i = 0; i < PATTERN_MAX - 1; i++) win[i] = win[i + 1];
          win[PATTERN_MAX - 1] = b;
          txt_cnt++;
          if (!hit_seen && !pat_ovf && pat_len != 0 && txt_cnt >= pat_len) begin
            hit = 1'b1;
            for (int i = 0; i < pat_len; i++) begin
              if (pat_mem[i] != win[PATTERN_MAX - pat_len + i]) hit = 1'b0;
            end
            if (hit) begin
              hit_seen = 1'b1;
              hit_pos  = txt_cnt - pat_len + 1;
            end
          end
        end
      end
      default: begin
        if (pat_ovf)
          a.position = '0;
        else if (pat_len == 0)
          a.position = 16'd1;
        else if (hit_seen)
          a.position = hit_pos[POS_W-1:0];
        else
          a.position = '0;
        a.overflow = ovf_seen;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] text_byte(input bit narrow);
    logic [7:0] alphabet [4];
    alphabet = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    return narrow ? alphabet[$urandom_range(3)] : 8'($urandom_range(255));
  endfunction

  // Offers one word, waits for it to be taken, then records what it should yield.
  task automatic send_word(input kind_t k, input logic [7:0] b, input bit typed = 1'b0,
                           input logic [POS_W-1:0] tpos = '0, input logic tovf = 1'b0);
    answer_t a;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_kind      <= 2'($urandom_range(3));
      in_data_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (search_step(k, b, a)) begin
      if (typed) begin
        a.position = tpos;
        a.overflow = tovf;
      end
      awaited_answers.push_back(a);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected result word: position %0d, overflow %0d",
               out_position, out_overflow);
        mismatch_count++;
      end else begin
        e = awaited_answers.pop_front();
        if (out_position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, out_position);
          mismatch_count++;
        end
        if (out_overflow !== e.overflow) begin
          $error("overflow: expected %0d, got %0d", e.overflow, out_overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    int         phase;
    int         roll;
    int         plen;
    int         tlen;
    int         at;
    int         late_at;
    bit         narrow;

    clear_search();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      repeat (script[r].reps) begin
        send_word(script[r].kind, script[r].data, script[r].typed, script[r].pos, script[r].ovf);
      end
    end

    words_sent = 0;
    while (words_sent < RANDOM_ITEMS) begin
      phase          = (words_sent * 4) / RANDOM_ITEMS;
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      roll           = $urandom_range(99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(kind_t'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end else begin
        narrow = ($urandom_range(99) < 70);
        roll   = $urandom_range(99);
        if (roll < 70)
          plen = $urandom_range(0, 5);
        else if (roll < 88)
          plen = $urandom_range(6, 16);
        else if (roll < 95)
          plen = PATTERN_MAX;
        else
          plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 2);
        tlen = $urandom_range(0, (plen > 16) ? plen + 4 : plen + 12);
        pat.delete();
        txt.delete();
        for (int i = 0; i < plen; i++) pat.push_back(text_byte(narrow));
        for (int i = 0; i < tlen; i++) txt.push_back(text_byte(narrow));
        // Where the text is long enough, most searches plant the pattern somewhere in it.
        if (tlen >= plen && plen <= PATTERN_MAX && $urandom_range(99) < 60) begin
          at = $urandom_range(0, tlen - plen);
          for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
        end
        late_at = (tlen > 0 && $urandom_range(99) < 10) ? $urandom_range(1, tlen) : -1;
        send_word(KIND_START, 8'($urandom_range(255)));
        foreach (pat[i]) send_word(KIND_PATTERN, pat[i]);
        foreach (txt[i]) begin
          if (i == late_at) send_word(KIND_PATTERN, text_byte(narrow));
          send_word(KIND_TEXT, txt[i]);
        end
        send_word(KIND_END, 8'($urandom_range(255)));
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 4)) send_word(KIND_TEXT, text_byte(narrow));
          send_word(KIND_END, 8'($urandom_range(255)));
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
